/* rtl/slerp_pkg.sv */
// Shared types, constants and angle table for the quaternion slerp pipeline.
`default_nettype none

package slerp_pkg;

	localparam int FRAC_BITS = 14;
	localparam int SQ_N      = 32;
	localparam int CORD_N    = 30;
	localparam int DIV_N     = 32;

	localparam logic [14:0] THR_RESET       = 15'd16382;
	localparam logic [32:0] CORDIC_INV_GAIN = 33'd652032874;
	localparam logic [30:0] ONE30           = 31'h4000_0000;

	typedef enum logic [1:0] {
		PATH_FIRST  = 2'd0,
		PATH_SECOND = 2'd1,
		PATH_LINEAR = 2'd2,
		PATH_SPHERE = 2'd3
	} path_t;

	typedef struct packed {
		logic [3:0][15:0] a;
		logic [3:0][16:0] b;
		logic [15:0]      t;
		path_t            path;
	} item_t;

	localparam logic [29:0] ATAN_TAB [11] = '{
		30'd843314857, 30'd497837829, 30'd263043836, 30'd133525158,
		30'd67021686,  30'd33543515,  30'd16775850,  30'd8388437,
		30'd4194282,   30'd2097149,   30'd1048575
	};

	function automatic logic [29:0] angle_step(input int i);
		if (i < 11) begin
			return ATAN_TAB[i[3:0]];
		end
		return 30'((64'd1 << (30 - i)) - 64'd1);
	endfunction

endpackage

`default_nettype wire

/* rtl/quaternion_slerp_top.sv */
// Pipelined fixed-point quaternion slerp with threshold register and output skid.
`default_nettype none

// Channel   Dir  Handshake              Payload (lowest bits first)
// s_axis    in   s_axis_tvalid/tready    tdata: q0_x q0_y q0_z q0_w q1_x q1_y q1_z q1_w blend
// m_axis    out  m_axis_tvalid/tready    tdata: out_x out_y out_z out_w; tuser: path
// cfg       in   cfg_valid/cfg_ready     cfg_data: parallel_threshold
//
// One item per cycle sustained while the skid entry is empty. Items pass the 32-step
// square root, the 30-step CORDIC vectoring and rotation chains and the 32-step divider.
// Reset clears valid bits and loads the threshold with its default; no clearing pass.
// All stages advance together; only the output skid entry stops the pipe, so a
// stalled sink never loses or repeats an item.

module quaternion_slerp_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [143:0] s_axis_tdata,   // q0_x q0_y q0_z q0_w q1_x q1_y q1_z q1_w blend
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [63:0]  m_axis_tdata,   // out_x out_y out_z out_w
	output logic [1:0]   m_axis_tuser,   // path
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [14:0]  cfg_data        // parallel_threshold
);
	import slerp_pkg::*;

	// stage map
	localparam int ST_CS = 3;                          // dot -> cos, path decision
	localparam int ST_M1 = 5 + SQ_N + 1 + CORD_N + 1;  // t * omega
	localparam int ST_K  = ST_M1 + 1 + CORD_N + 1 + DIV_N + 1;
	localparam int NSTG  = ST_K + 2;
	localparam int SH    = 30 - FRAC_BITS;

	logic [14:0] thr_q;
	logic        adv, in_fire;

	// output register and skid entry
	logic        o_v_q, sk_v_q;
	logic [63:0] o_d_q, sk_d_q;
	path_t       o_p_q, sk_p_q;

	assign adv           = !sk_v_q;
	assign in_fire       = s_axis_tvalid && adv;
	assign s_axis_tready = adv;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_valid) begin
			thr_q <= cfg_data;
		end
	end

	// ---------------- valid chain and item payload ----------------
	logic [NSTG-1:0] v_s;
	item_t           it_s [NSTG];
	item_t           it1_d, it4_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (adv) begin
			v_s <= {v_s[NSTG-2:0], in_fire};
		end
	end

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			it1_d.a[i] = s_axis_tdata[16*i +: 16];
			it1_d.b[i] = {s_axis_tdata[64+16*i+15], s_axis_tdata[64+16*i +: 16]};
		end
		it1_d.t = s_axis_tdata[143:128];
		// clamp of the blend factor decides the bypass cases up front
		if ($signed(it1_d.t) <= 16'sd0) begin
			it1_d.path = PATH_FIRST;
		end else if ($signed({it1_d.t[15], it1_d.t}) >= $signed(17'(1 << FRAC_BITS))) begin
			it1_d.path = PATH_SECOND;
		end else begin
			it1_d.path = PATH_SPHERE;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			it_s[0] <= it1_d;
			for (int k = 1; k < NSTG; k++) begin
				if (k == ST_CS) begin
					it_s[k] <= it4_d;
				end else begin
					it_s[k] <= it_s[k-1];
				end
			end
		end
	end

	// ---------------- dot product ----------------
	logic signed [31:0] prod_s2 [4];
	logic signed [33:0] dot_s3;
	logic signed [33:0] dot_d;

	always_comb begin
		dot_d = '0;
		for (int i = 0; i < 4; i++) begin
			dot_d = dot_d + 34'(prod_s2[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 4; i++) begin
				prod_s2[i] <= $signed(it_s[0].a[i]) * $signed(it_s[0].b[i][15:0]);
			end
			dot_s3 <= dot_d;
		end
	end

	// ---------------- cosine, hemisphere flip, path ----------------
	logic [32:0]          dabs_d;
	logic [62-FRAC_BITS:0] cfull_d;
	logic [30:0]          c30_d, c30_s4, c30_s5;
	logic                 lin_d;
	logic [61:0]          csq_s5;

	always_comb begin
		dabs_d  = dot_s3[33] ? 33'(-dot_s3) : 33'(dot_s3);
		cfull_d = ((63-FRAC_BITS)'(dabs_d) << SH) >> FRAC_BITS;
		c30_d   = (cfull_d > (63-FRAC_BITS)'(ONE30)) ? ONE30 : cfull_d[30:0];
		// zero sine also falls back to the linear blend
		lin_d   = (dabs_d > (33'(thr_q) << FRAC_BITS)) || (c30_d == ONE30);
		it4_d   = it_s[ST_CS-1];
		if (it4_d.path == PATH_SPHERE) begin
			if (dot_s3[33]) begin
				for (int i = 0; i < 4; i++) begin
					it4_d.b[i] = 17'(-$signed(it4_d.b[i]));
				end
			end
			it4_d.path = lin_d ? PATH_LINEAR : PATH_SPHERE;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c30_s4 <= c30_d;
			c30_s5 <= c30_s4;
			csq_s5 <= 62'(c30_s4) * 62'(c30_s4);
		end
	end

	// ---------------- square root, one result bit per stage ----------------
	logic [60:0] sq_n_s [SQ_N+1];
	logic [62:0] sq_r_s [SQ_N+1];
	logic [30:0] sq_c_s [SQ_N+1];
	logic [60:0] sq_n_d [SQ_N+1];
	logic [62:0] sq_r_d [SQ_N+1];

	always_comb begin
		logic [62:0] bitj;
		logic [63:0] sum;
		sq_n_d[0] = 61'((62'd1 << 60) - csq_s5);
		sq_r_d[0] = '0;
		for (int j = 0; j < SQ_N; j++) begin
			bitj = 63'd1 << (62 - 2*j);
			sum  = 64'(sq_r_s[j]) + 64'(bitj);
			if (64'(sq_n_s[j]) >= sum) begin
				sq_n_d[j+1] = 61'(64'(sq_n_s[j]) - sum);
				sq_r_d[j+1] = (sq_r_s[j] >> 1) + bitj;
			end else begin
				sq_n_d[j+1] = sq_n_s[j];
				sq_r_d[j+1] = sq_r_s[j] >> 1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j <= SQ_N; j++) begin
				sq_n_s[j] <= sq_n_d[j];
				sq_r_s[j] <= sq_r_d[j];
				sq_c_s[j] <= (j == 0) ? c30_s5 : sq_c_s[j-1];
			end
		end
	end

	// ---------------- CORDIC vectoring: omega = atan2(s, c) ----------------
	logic signed [32:0] at_x_s [CORD_N+1], at_y_s [CORD_N+1], at_z_s [CORD_N+1];
	logic signed [32:0] at_x_d [CORD_N+1], at_y_d [CORD_N+1], at_z_d [CORD_N+1];
	logic [30:0]        at_sd_s [CORD_N+1];

	always_comb begin
		logic signed [32:0] dx, dy, st;
		at_x_d[0] = 33'(sq_c_s[SQ_N]);
		at_y_d[0] = 33'(sq_r_s[SQ_N][30:0]);
		at_z_d[0] = '0;
		for (int j = 0; j < CORD_N; j++) begin
			dx = at_y_s[j] >>> j;
			dy = at_x_s[j] >>> j;
			st = 33'(angle_step(j));
			if (at_y_s[j] > 33'sd0) begin
				at_x_d[j+1] = at_x_s[j] + dx;
				at_y_d[j+1] = at_y_s[j] - dy;
				at_z_d[j+1] = at_z_s[j] + st;
			end else begin
				at_x_d[j+1] = at_x_s[j] - dx;
				at_y_d[j+1] = at_y_s[j] + dy;
				at_z_d[j+1] = at_z_s[j] - st;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j <= CORD_N; j++) begin
				at_x_s[j]  <= at_x_d[j];
				at_y_s[j]  <= at_y_d[j];
				at_z_s[j]  <= at_z_d[j];
				at_sd_s[j] <= (j == 0) ? sq_r_s[SQ_N][30:0] : at_sd_s[j-1];
			end
		end
	end

	// ---------------- split angle: a1 = t * omega, a0 = omega - a1 ----------------
	logic [60:0] m1_p_s;
	logic [30:0] m1_om_s, m1_sd_s;
	logic [29:0] t30_d;

	assign t30_d = 30'(it_s[ST_M1-1].t) << SH;

	always_ff @(posedge clk) begin
		if (adv) begin
			m1_p_s  <= 61'(t30_d) * 61'(at_z_s[CORD_N][30:0]);
			m1_om_s <= at_z_s[CORD_N][30:0];
			m1_sd_s <= at_sd_s[CORD_N];
		end
	end

	// ---------------- two CORDIC rotation chains: sin(a0), sin(a1) ----------------
	logic signed [32:0] sn_x_s [CORD_N+1][2], sn_y_s [CORD_N+1][2], sn_z_s [CORD_N+1][2];
	logic signed [32:0] sn_x_d [CORD_N+1][2], sn_y_d [CORD_N+1][2], sn_z_d [CORD_N+1][2];
	logic [30:0]        sn_sd_s [CORD_N+1];

	always_comb begin
		logic signed [32:0] dx, dy, st;
		logic [30:0]        a1;
		a1 = m1_p_s[60:30];
		sn_z_d[0][0] = 33'(m1_om_s - a1);
		sn_z_d[0][1] = 33'(a1);
		for (int u = 0; u < 2; u++) begin
			sn_x_d[0][u] = CORDIC_INV_GAIN;
			sn_y_d[0][u] = '0;
		end
		for (int j = 0; j < CORD_N; j++) begin
			for (int u = 0; u < 2; u++) begin
				dx = sn_y_s[j][u] >>> j;
				dy = sn_x_s[j][u] >>> j;
				st = 33'(angle_step(j));
				if (sn_z_s[j][u] >= 33'sd0) begin
					sn_x_d[j+1][u] = sn_x_s[j][u] - dx;
					sn_y_d[j+1][u] = sn_y_s[j][u] + dy;
					sn_z_d[j+1][u] = sn_z_s[j][u] - st;
				end else begin
					sn_x_d[j+1][u] = sn_x_s[j][u] + dx;
					sn_y_d[j+1][u] = sn_y_s[j][u] - dy;
					sn_z_d[j+1][u] = sn_z_s[j][u] + st;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j <= CORD_N; j++) begin
				for (int u = 0; u < 2; u++) begin
					sn_x_s[j][u] <= sn_x_d[j][u];
					sn_y_s[j][u] <= sn_y_d[j][u];
					sn_z_s[j][u] <= sn_z_d[j][u];
				end
				sn_sd_s[j] <= (j == 0) ? m1_sd_s : sn_sd_s[j-1];
			end
		end
	end

	// ---------------- restoring dividers: k = sin * 2^30 / s ----------------
	logic [31:0] dv_r_s [DIV_N+1][2], dv_q_s [DIV_N+1][2];
	logic [31:0] dv_r_d [DIV_N+1][2], dv_q_d [DIV_N+1][2];
	logic [1:0]  dv_lo_s [DIV_N+1][2], dv_lo_d [2];
	logic        dv_ov_s [DIV_N+1][2], dv_ov_d [2];
	logic [30:0] dv_den_s [DIV_N+1];

	always_comb begin
		logic signed [32:0] y;
		logic [30:0]        sc;
		logic [31:0]        rr;
		logic               nb;
		for (int u = 0; u < 2; u++) begin
			y  = sn_y_s[CORD_N][u];
			sc = (y < 33'sd0) ? 31'd0 : (y > 33'(ONE30)) ? ONE30 : y[30:0];
			// quotient at or above 2^32 is clamped outright
			dv_ov_d[u]   = (sc >> 2) >= sn_sd_s[CORD_N];
			dv_r_d[0][u] = 32'(sc >> 2);
			dv_q_d[0][u] = '0;
			dv_lo_d[u]   = sc[1:0];
		end
		for (int j = 0; j < DIV_N; j++) begin
			for (int u = 0; u < 2; u++) begin
				nb = (j == 0) ? dv_lo_s[j][u][1] : (j == 1) ? dv_lo_s[j][u][0] : 1'b0;
				rr = {dv_r_s[j][u][30:0], nb};
				if (rr >= 32'(dv_den_s[j])) begin
					dv_r_d[j+1][u] = rr - 32'(dv_den_s[j]);
					dv_q_d[j+1][u] = dv_q_s[j][u] | (32'd1 << (DIV_N - 1 - j));
				end else begin
					dv_r_d[j+1][u] = rr;
					dv_q_d[j+1][u] = dv_q_s[j][u];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j <= DIV_N; j++) begin
				for (int u = 0; u < 2; u++) begin
					dv_r_s[j][u]  <= dv_r_d[j][u];
					dv_q_s[j][u]  <= dv_q_d[j][u];
					dv_lo_s[j][u] <= (j == 0) ? dv_lo_d[u] : dv_lo_s[j-1][u];
					dv_ov_s[j][u] <= (j == 0) ? dv_ov_d[u] : dv_ov_s[j-1][u];
				end
				dv_den_s[j] <= (j == 0) ? sn_sd_s[CORD_N] : dv_den_s[j-1];
			end
		end
	end

	// ---------------- weight select ----------------
	// bypass and linear cases reuse the final multiply with Q30 weights
	logic [31:0] k0_s, k1_s, k0_d, k1_d, kd [2], lin_k1;
	item_t       itk;

	always_comb begin
		itk    = it_s[ST_K-1];
		lin_k1 = 32'(itk.t[FRAC_BITS-1:0]) << SH;
		for (int u = 0; u < 2; u++) begin
			if (dv_ov_s[DIV_N][u] || dv_q_s[DIV_N][u] > 32'h8000_0000) begin
				kd[u] = 32'h8000_0000;
			end else begin
				kd[u] = dv_q_s[DIV_N][u];
			end
		end
		case (itk.path)
			PATH_FIRST: begin
				k0_d = 32'(ONE30);
				k1_d = '0;
			end
			PATH_SECOND: begin
				k0_d = '0;
				k1_d = 32'(ONE30);
			end
			PATH_LINEAR: begin
				k0_d = 32'(ONE30) - lin_k1;
				k1_d = lin_k1;
			end
			default: begin
				k0_d = kd[0];
				k1_d = kd[1];
			end
		endcase
	end

	// ---------------- final products, rounding, saturation ----------------
	logic signed [48:0] mp0_s [4];
	logic signed [49:0] mp1_s [4];
	logic [63:0]        res_d;

	always_ff @(posedge clk) begin
		if (adv) begin
			k0_s <= k0_d;
			k1_s <= k1_d;
			for (int i = 0; i < 4; i++) begin
				mp0_s[i] <= $signed({1'b0, k0_s}) * $signed(it_s[ST_K].a[i]);
				mp1_s[i] <= $signed({1'b0, k1_s}) * $signed(it_s[ST_K].b[i]);
			end
		end
	end

	always_comb begin
		logic signed [51:0] acc;
		logic signed [21:0] sh;
		for (int i = 0; i < 4; i++) begin
			acc = 52'(mp0_s[i]) + 52'(mp1_s[i]) + 52'sd536870912;
			sh  = 22'(acc >>> 30);
			if (sh > 22'sd32767) begin
				res_d[16*i +: 16] = 16'h7FFF;
			end else if (sh < -22'sd32768) begin
				res_d[16*i +: 16] = 16'h8000;
			end else begin
				res_d[16*i +: 16] = sh[15:0];
			end
		end
	end

	// ---------------- output register with skid entry ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_v_q  <= 1'b0;
			sk_v_q <= 1'b0;
		end else if (m_axis_tready || !o_v_q) begin
			if (sk_v_q) begin
				o_v_q  <= 1'b1;
				sk_v_q <= 1'b0;
			end else begin
				o_v_q <= v_s[NSTG-1];
			end
		end else if (v_s[NSTG-1] && adv) begin
			sk_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (m_axis_tready || !o_v_q) begin
			o_d_q <= sk_v_q ? sk_d_q : res_d;
			o_p_q <= sk_v_q ? sk_p_q : it_s[NSTG-1].path;
		end else if (adv) begin
			sk_d_q <= res_d;
			sk_p_q <= it_s[NSTG-1].path;
		end
	end

	assign m_axis_tvalid = o_v_q;
	assign m_axis_tdata  = o_d_q;
	assign m_axis_tuser  = o_p_q;

`ifndef NO_ASSERTIONS
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		sk_v_q |-> o_v_q)
		else $error("skid entry holds an item while the output register is empty");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		sk_v_q && m_axis_tready |=> !sk_v_q)
		else $error("skid entry not drained after the sink took an item");

	a_pipe_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		sk_v_q |=> $stable(v_s))
		else $error("pipeline moved while the skid entry was full");

	// weights registered in k0_s/k1_s belong to the item held in stage ST_K
	a_linear_weights: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[ST_K] && it_s[ST_K].path == PATH_LINEAR |->
			(33'(k0_s) + 33'(k1_s)) == 33'(ONE30))
		else $error("linear blend weights do not sum to one");
`endif

endmodule

`default_nettype wire
